// ===== sv/kfe_pkg.sv =====
// Shared constants, types and pointer helpers for the key FIFO escape combiner.
package kfe_pkg;

    localparam int unsigned DEPTH = 16;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned HELD_W = $clog2(DEPTH + 1);
    localparam int unsigned CODE_W = 24;
    localparam int unsigned CNT_W = 5;

    localparam logic [7:0] KEY_ESC = 8'h1B;
    localparam logic [7:0] KEY_BRACKET = 8'h5B;
    localparam logic [CODE_W-1:0] SEQ_PREFIX = 24'd1792768;
    localparam int unsigned SEQ_LEN = 3;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [HELD_W-1:0] held_t;

    typedef enum logic [1:0] {
        FUNC_PUSH = 2'd0,
        FUNC_POP  = 2'd1,
        FUNC_PEEK = 2'd2,
        FUNC_NOP  = 2'd3
    } func_t;

    // Outcome of looking at the head bytes of the FIFO.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              is_sequence;
        logic [7:0]        arrow_letter;
        logic              takes_three;
    } decode_t;

    function automatic ptr_t next_ptr(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    function automatic held_t held_bytes(input ptr_t rd, input ptr_t wr, input logic full);
        held_t r;
        if (full)
            r = HELD_W'(DEPTH);
        else if (wr >= rd)
            r = HELD_W'(wr) - HELD_W'(rd);
        else
            r = HELD_W'(DEPTH) - (HELD_W'(rd) - HELD_W'(wr));
        return r;
    endfunction

endpackage

// ===== sv/key_fifo_escape_combiner.sv =====
// Top level of the key FIFO escape combiner: byte store, pointers and result register.
//
// Usage. A command word (func, push_byte) is taken at a rising clock edge where
// start is high and busy is low. busy is never raised, so a command may be
// issued in every cycle. func selects push, pop, peek or no operation.
//
// Each command produces exactly one result word. It appears on code,
// code_valid, is_sequence, arrow_letter, fill_count and push_dropped in the
// cycle after the command was taken, marked by done for exactly one cycle.
// The receiver cannot stall; it must take the word while done is high.
//
// Throughput is one command per cycle. That rate is set by the single pass through
// the three read ports of the 16-entry byte store, the escape decode and the
// pointer update, all between the command edge and the result register.
//
// A pop on an ESC with at least three bytes held consumes three bytes; with
// '[' as the second byte the word carries the packed code and arrow letter.
// Reset clears both pointers, the full flag and done; the store keeps its
// contents, which are never read before being written.
module key_fifo_escape_combiner (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                func,
    input  logic [7:0]                push_byte,
    output logic                      done,
    output logic [kfe_pkg::CODE_W-1:0] code,
    output logic                      code_valid,
    output logic                      is_sequence,
    output logic [7:0]                arrow_letter,
    output logic [kfe_pkg::CNT_W-1:0] fill_count,
    output logic                      push_dropped
);
    import kfe_pkg::*;

    // Byte store, with no reset: only held entries are ever read.
    logic [7:0] store_mem [DEPTH];

    ptr_t  read_ptr_reg, read_ptr_next;
    ptr_t  write_ptr_reg, write_ptr_next;
    logic  full_reg, full_next;

    logic                done_reg;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic                valid_reg, valid_next;
    logic                seq_reg, seq_next;
    logic [7:0]          letter_reg, letter_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                dropped_reg, dropped_next;

    func_t   op;
    logic    accept;
    logic    store_write;
    ptr_t    ptr1, ptr2, wr_inc;
    held_t   held_now;
    decode_t dec;

    assign busy = 1'b0;
    assign accept = start && !busy;
    assign op = func_t'(func);

    assign ptr1 = next_ptr(read_ptr_reg);
    assign ptr2 = next_ptr(ptr1);
    assign wr_inc = next_ptr(write_ptr_reg);
    assign held_now = held_bytes(read_ptr_reg, write_ptr_reg, full_reg);

    kfe_decode u_decode (
        .head_byte   (store_mem[read_ptr_reg]),
        .second_byte (store_mem[ptr1]),
        .third_byte  (store_mem[ptr2]),
        .three_held  (held_now >= HELD_W'(SEQ_LEN)),
        .dec         (dec)
    );

    // Command execution: next pointers and the result word.
    always_comb
    begin
        read_ptr_next = read_ptr_reg;
        write_ptr_next = write_ptr_reg;
        full_next = full_reg;
        store_write = 1'b0;
        code_next = '0;
        valid_next = 1'b0;
        seq_next = 1'b0;
        letter_next = '0;
        dropped_next = 1'b0;
        unique case (op)
            FUNC_PUSH:
            begin
                if (full_reg)
                    dropped_next = 1'b1;
                else
                begin
                    store_write = 1'b1;
                    write_ptr_next = wr_inc;
                    full_next = (wr_inc == read_ptr_reg);
                end
            end
            FUNC_POP, FUNC_PEEK:
            begin
                if (held_now != '0)
                begin
                    valid_next = 1'b1;
                    code_next = dec.code;
                    seq_next = dec.is_sequence;
                    letter_next = dec.arrow_letter;
                    if (op == FUNC_POP)
                    begin
                        read_ptr_next = dec.takes_three ? next_ptr(ptr2) : ptr1;
                        full_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        count_next = CNT_W'(held_bytes(read_ptr_next, write_ptr_next, full_next));
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_write)
            store_mem[write_ptr_reg] <= push_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_ptr_reg <= '0;
            write_ptr_reg <= '0;
            full_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                read_ptr_reg <= read_ptr_next;
                write_ptr_reg <= write_ptr_next;
                full_reg <= full_next;
            end
        end
    end

    // Result payload needs no reset; done qualifies it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg <= code_next;
            valid_reg <= valid_next;
            seq_reg <= seq_next;
            letter_reg <= letter_next;
            count_reg <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    assign done = done_reg;
    assign code = code_reg;
    assign code_valid = valid_reg;
    assign is_sequence = seq_reg;
    assign arrow_letter = letter_reg;
    assign fill_count = count_reg;
    assign push_dropped = dropped_reg;

endmodule

// ===== sv/kfe_decode.sv =====
// Classifies the head bytes as a plain key, a lone ESC or a packed ESC '[' sequence.
module kfe_decode (
    input  logic [7:0]      head_byte,
    input  logic [7:0]      second_byte,
    input  logic [7:0]      third_byte,
    input  logic            three_held,
    output kfe_pkg::decode_t dec
);
    import kfe_pkg::*;

    always_comb
    begin
        dec.code = CODE_W'(head_byte);
        dec.is_sequence = 1'b0;
        dec.arrow_letter = '0;
        dec.takes_three = 1'b0;
        if (head_byte == KEY_ESC && three_held)
        begin
            dec.takes_three = 1'b1;
            if (second_byte == KEY_BRACKET)
            begin
                dec.code = SEQ_PREFIX | CODE_W'(third_byte);
                dec.is_sequence = 1'b1;
                dec.arrow_letter = third_byte;
            end
        end
    end

endmodule

// ===== test/key_fifo_escape_combiner_tb.sv =====
// Self-checking testbench for the key FIFO escape combiner.
`timescale 1ns / 1ps

module key_fifo_escape_combiner_tb;

    import kfe_pkg::*;

    localparam int unsigned CLK_PERIOD  = 10;
    localparam int unsigned CYCLE_LIMIT = 60000;
    localparam int unsigned RANDOM_OPS  = 700;
    localparam int unsigned MAX_SHOWN   = 40;

    // One result word as the block should present it. accepted_at holds the cycle in
    // which the command was taken, so that a word cannot be matched against an
    // expectation that was only queued in the same clock edge.
    typedef struct {
        logic [CODE_W-1:0] code;
        logic              code_valid;
        logic              is_sequence;
        logic [7:0]        arrow_letter;
        logic [CNT_W-1:0]  fill_count;
        logic              push_dropped;
        longint unsigned   accepted_at;
    } key_word_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    func_t             func;
    logic [7:0]        push_byte;
    logic              done;
    logic [CODE_W-1:0] code;
    logic              code_valid;
    logic              is_sequence;
    logic [7:0]        arrow_letter;
    logic [CNT_W-1:0]  fill_count;
    logic              push_dropped;

    // Shadow copy of the FIFO that the predictor keeps in step with the block.
    logic [7:0]        shadow_bytes [DEPTH] = '{default: 8'h00};
    ptr_t              shadow_rd = '0;
    ptr_t              shadow_wr = '0;
    logic              shadow_full = 1'b0;

    key_word_t         pending_codes [$];
    key_word_t         arrived;
    longint unsigned   cycle_count = 0;
    int unsigned       mismatch_count = 0;
    bit                idle_on = 1'b1;

    key_fifo_escape_combiner i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .push_byte    (push_byte),
        .done         (done),
        .code         (code),
        .code_valid   (code_valid),
        .is_sequence  (is_sequence),
        .arrow_letter (arrow_letter),
        .fill_count   (fill_count),
        .push_dropped (push_dropped)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // The cycle counter also acts as the watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL key_fifo_escape_combiner");
            $finish;
        end
    end

    // Pointer step with wrap at the end of the store.
    function automatic ptr_t step_index(input ptr_t p);
        if (p == ptr_t'(DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    // Number of bytes held in the shadow FIFO; the pointer difference wraps at the
    // store depth.
    function automatic int unsigned shadow_held();
        if (shadow_full)
            return DEPTH;
        return 32'(ptr_t'(shadow_wr - shadow_rd));
    endfunction

    // Applies one command to the shadow FIFO and returns the word the block should give.
    // A pop or peek on ESC with three bytes held covers three bytes; only a second byte
    // of '[' turns it into a packed sequence, otherwise plain ESC is reported.
    function automatic key_word_t combine_key_op(input func_t op, input logic [7:0] b);
        key_word_t   w;
        int unsigned held;
        int unsigned span;
        ptr_t        p0;
        ptr_t        p1;
        ptr_t        p2;
        w = '{code: '0, code_valid: 1'b0, is_sequence: 1'b0, arrow_letter: '0,
              fill_count: '0, push_dropped: 1'b0, accepted_at: 0};
        held = shadow_held();
        case (op)
            FUNC_PUSH:
            begin
                if (shadow_full)
                    w.push_dropped = 1'b1;
                else
                begin
                    shadow_bytes[shadow_wr] = b;
                    shadow_wr = step_index(shadow_wr);
                    if (shadow_wr == shadow_rd)
                        shadow_full = 1'b1;
                end
            end
            FUNC_POP, FUNC_PEEK:
            begin
                if (held != 0)
                begin
                    p0 = shadow_rd;
                    p1 = step_index(p0);
                    p2 = step_index(p1);
                    span = 1;
                    w.code_valid = 1'b1;
                    w.code = CODE_W'(shadow_bytes[p0]);
                    if (shadow_bytes[p0] == KEY_ESC && held >= SEQ_LEN)
                    begin
                        span = SEQ_LEN;
                        if (shadow_bytes[p1] == KEY_BRACKET)
                        begin
                            w.code = SEQ_PREFIX | CODE_W'(shadow_bytes[p2]);
                            w.is_sequence = 1'b1;
                            w.arrow_letter = shadow_bytes[p2];
                        end
                    end
                    if (op == FUNC_POP)
                    begin
                        repeat (span) shadow_rd = step_index(shadow_rd);
                        shadow_full = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        w.fill_count = CNT_W'(shadow_held());
        return w;
    endfunction

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string what, input longint unsigned want_v,
                                   input longint unsigned got_v);
        if (mismatch_count < MAX_SHOWN)
            $display("ERROR cycle %0d: %s expected 0x%0h got 0x%0h",
                     cycle_count, what, want_v, got_v);
        mismatch_count++;
    endtask

    // Result checker. Outputs are sampled at the edge that ends the strobe cycle, so the
    // values read here are those the block held during that cycle.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_codes.size() == 0 || pending_codes[0].accepted_at >= cycle_count)
                report_mismatch("result word with nothing pending", 0, code);
            else
            begin
                arrived = pending_codes.pop_front();
                if (code !== arrived.code)
                    report_mismatch("code", arrived.code, code);
                if (code_valid !== arrived.code_valid)
                    report_mismatch("code_valid", arrived.code_valid, code_valid);
                if (is_sequence !== arrived.is_sequence)
                    report_mismatch("is_sequence", arrived.is_sequence, is_sequence);
                if (arrow_letter !== arrived.arrow_letter)
                    report_mismatch("arrow_letter", arrived.arrow_letter, arrow_letter);
                if (fill_count !== arrived.fill_count)
                    report_mismatch("fill_count", arrived.fill_count, fill_count);
                if (push_dropped !== arrived.push_dropped)
                    report_mismatch("push_dropped", arrived.push_dropped, push_dropped);
            end
        end
    end

    // Presents one command word and holds it until the block takes it. The expectation
    // is queued at the accepting edge. Afterwards the sender may sometimes idle, and
    // while it does the command inputs carry junk that must be ignored.
    task automatic send_key_op(input func_t op, input logic [7:0] b);
        key_word_t w;
        start     <= 1'b1;
        func      <= op;
        push_byte <= b;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        w = combine_key_op(op, b);
        w.accepted_at = cycle_count;
        pending_codes.push_back(w);
        if (idle_on && $urandom_range(99) < 14)
        begin
            start     <= 1'b0;
            func      <= func_t'($urandom_range(3));
            push_byte <= 8'($urandom_range(255));
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Stops issuing commands until every pending word has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
    endtask

    // Pop, peek and the unused selector on an empty FIFO must report no code.
    task automatic test_empty_fifo();
        send_key_op(FUNC_POP, 8'hFF);
        send_key_op(FUNC_PEEK, 8'h00);
        send_key_op(FUNC_NOP, 8'hFF);
        wait_for_results();
    endtask

    // ESC with fewer than three bytes held is returned as a single plain ESC.
    task automatic test_short_escape();
        send_key_op(FUNC_PUSH, KEY_ESC);
        send_key_op(FUNC_PUSH, KEY_BRACKET);
        send_key_op(FUNC_PEEK, 8'h00);
        send_key_op(FUNC_POP, 8'h00);
        send_key_op(FUNC_POP, 8'h00);
        wait_for_results();
    endtask

    // Fills the FIFO across the wrap point, pushes into a full FIFO, then reads both a
    // packed sequence and an ESC whose second byte is not a bracket.
    task automatic test_full_and_drop();
        logic [7:0] fill_bytes [16];
        fill_bytes = '{8'h1B, 8'h5B, 8'h41, 8'h1B, 8'h00, 8'hFF, 8'h1B, 8'h5B,
                       8'h44, 8'h7F, 8'h80, 8'h01, 8'h1B, 8'h5B, 8'h43, 8'h1B};
        foreach (fill_bytes[i])
            send_key_op(FUNC_PUSH, fill_bytes[i]);
        send_key_op(FUNC_PUSH, 8'hAA);
        send_key_op(FUNC_PEEK, 8'h55);
        send_key_op(FUNC_POP, 8'h00);
        send_key_op(FUNC_POP, 8'hFF);
        wait_for_results();
    endtask

    // Random traffic. Four in ten push picks are ESC '[' sequences with a random last byte;
    // the rest are lone ESC bytes, broken sequences and arbitrary bytes. The push share
    // swings between filling and draining phases so that both the full and the empty
    // FIFO are visited often. A stretch in the middle runs with no idling.
    task automatic test_random_traffic(input int unsigned count);
        int unsigned issued;
        int unsigned phase_left;
        int unsigned push_share;
        int unsigned pick;
        bit          filling;
        bit          drained;
        issued     = 0;
        phase_left = 0;
        filling    = 1'b0;
        drained    = 1'b0;
        while (issued < count)
        begin
            if (phase_left == 0)
            begin
                filling    = ~filling;
                phase_left = $urandom_range(30, 80);
            end
            push_share = filling ? 65 : 30;
            idle_on = !(issued >= 250 && issued < 400);
            if (!drained && issued >= 350)
            begin
                wait_for_results();
                drained = 1'b1;
            end
            if ($urandom_range(99) < push_share)
            begin
                pick = $urandom_range(9);
                if (pick < 5)
                begin
                    send_key_op(FUNC_PUSH, KEY_ESC);
                    send_key_op(FUNC_PUSH, (pick == 0) ? 8'($urandom_range(255)) : KEY_BRACKET);
                    send_key_op(FUNC_PUSH, 8'($urandom_range(255)));
                    issued += 3;
                end
                else
                begin
                    send_key_op(FUNC_PUSH, (pick == 5) ? KEY_ESC : 8'($urandom_range(255)));
                    issued++;
                end
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 65)
                    send_key_op(FUNC_POP, 8'($urandom_range(255)));
                else if (pick < 90)
                    send_key_op(FUNC_PEEK, 8'($urandom_range(255)));
                else
                    send_key_op(FUNC_NOP, 8'($urandom_range(255)));
                issued++;
            end
            phase_left = (phase_left > 0) ? phase_left - 1 : 0;
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        start     = 1'b0;
        func      = FUNC_NOP;
        push_byte = 8'h00;
        rst_n     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_fifo();
        test_short_escape();
        test_full_and_drop();
        test_random_traffic(RANDOM_OPS);

        // Let the last word arrive, then give any stray strobe time to show.
        wait_for_results();
        repeat (5) @(posedge clk);
        while (pending_codes.size() != 0)
        begin
            arrived = pending_codes.pop_front();
            report_mismatch("word never arrived, code", arrived.code, 0);
        end
        if (mismatch_count == 0)
            $display("PASS key_fifo_escape_combiner");
        else
            $display("FAIL key_fifo_escape_combiner");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/kfe_pkg.sv
sv/kfe_decode.sv
sv/key_fifo_escape_combiner.sv
test/key_fifo_escape_combiner_tb.sv
